FILE: sv/pst_pkg.sv
// Shared types and constants for the plane side and ray test unit.
`default_nettype none
package pst_pkg;

    localparam logic [1:0] OP_POINT  = 2'd0;
    localparam logic [1:0] OP_SPHERE = 2'd1;
    localparam logic [1:0] OP_BOX    = 2'd2;
    localparam logic [1:0] OP_RAY    = 2'd3;

    localparam logic [1:0] SIDE_NEG      = 2'd0;
    localparam logic [1:0] SIDE_POS      = 2'd1;
    localparam logic [1:0] SIDE_ON       = 2'd2;
    localparam logic [1:0] SIDE_STRADDLE = 2'd3;

    localparam logic [2:0] REG_NORMAL_X = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z = 3'd2;
    localparam logic [2:0] REG_OFFSET   = 3'd3;
    localparam logic [2:0] REG_EPSILON  = 3'd4;

    localparam int DIV_STEPS = 32;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] plane_offset;
        logic [15:0]        epsilon;
    } pst_cfg_t;

    typedef struct packed {
        logic [1:0]  side;
        logic        is_ray;
        logic        parallel;
        logic        same_sign;
        logic [31:0] dist_sat;
    } pst_meta_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] num;
        logic [63:0] den;
        pst_meta_t   meta;
    } pst_div_req_t;

    typedef struct packed {
        logic        valid;
        logic        ovf;
        logic [31:0] quo;
        pst_meta_t   meta;
    } pst_div_rsp_t;

endpackage
`default_nettype wire

FILE: sv/pst_cfg_regs.sv
// APB register file holding the plane and tolerance.
`default_nettype none
module pst_cfg_regs (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output pst_pkg::pst_cfg_t     cfg
);
    import pst_pkg::*;

    pst_cfg_t cfg_reg;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.normal_x     <= '0;
            cfg_reg.normal_y     <= '0;
            cfg_reg.normal_z     <= '0;
            cfg_reg.plane_offset <= '0;
            cfg_reg.epsilon      <= 16'd1;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_NORMAL_X: cfg_reg.normal_x     <= pwdata;
                REG_NORMAL_Y: cfg_reg.normal_y     <= pwdata;
                REG_NORMAL_Z: cfg_reg.normal_z     <= pwdata;
                REG_OFFSET:   cfg_reg.plane_offset <= pwdata;
                REG_EPSILON:  cfg_reg.epsilon      <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_NORMAL_X: prdata = cfg_reg.normal_x;
            REG_NORMAL_Y: prdata = cfg_reg.normal_y;
            REG_NORMAL_Z: prdata = cfg_reg.normal_z;
            REG_OFFSET:   prdata = cfg_reg.plane_offset;
            REG_EPSILON:  prdata = {16'd0, cfg_reg.epsilon};
            default:      prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/pst_front.sv
// Front pipeline: input capture, products, dot sums and side classification.
`default_nettype none
module pst_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  pst_pkg::pst_cfg_t        cfg,
    input  wire logic                in_valid,
    input  wire logic [1:0]          opcode,
    input  wire logic signed [31:0]  pos_x,
    input  wire logic signed [31:0]  pos_y,
    input  wire logic signed [31:0]  pos_z,
    input  wire logic signed [31:0]  vec_x,
    input  wire logic signed [31:0]  vec_y,
    input  wire logic signed [31:0]  vec_z,
    input  wire logic [30:0]         radius,
    output pst_pkg::pst_div_req_t    req
);
    import pst_pkg::*;

    logic               s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic [1:0]         s1_op_reg, s2_op_reg, s3_op_reg;
    logic [30:0]        s1_rad_reg, s2_rad_reg, s3_rad_reg;
    logic signed [31:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic signed [31:0] s1_vx_reg, s1_vy_reg, s1_vz_reg;

    logic signed [63:0] s2_px_next, s2_py_next, s2_pz_next;
    logic signed [63:0] s2_vx_next, s2_vy_next, s2_vz_next;
    logic signed [63:0] s2_px_reg, s2_py_reg, s2_pz_reg;
    logic signed [63:0] s2_vx_reg, s2_vy_reg, s2_vz_reg;

    logic signed [63:0] s3_dist_next, s3_den_next, s3_dist_reg, s3_den_reg;
    logic [63:0]        s3_mb_next, s3_mb_reg;
    logic [63:0]        abs_x, abs_y, abs_z;

    logic signed [63:0] bound;
    logic [1:0]         mid;
    logic [63:0]        anom, aden;
    pst_div_req_t       s4_next, s4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg  <= opcode;
        s1_rad_reg <= radius;
        s1_px_reg  <= pos_x;
        s1_py_reg  <= pos_y;
        s1_pz_reg  <= pos_z;
        s1_vx_reg  <= vec_x;
        s1_vy_reg  <= vec_y;
        s1_vz_reg  <= vec_z;
    end

    always_comb
    begin
        s2_px_next = 64'(cfg.normal_x) * 64'(s1_px_reg);
        s2_py_next = 64'(cfg.normal_y) * 64'(s1_py_reg);
        s2_pz_next = 64'(cfg.normal_z) * 64'(s1_pz_reg);
        s2_vx_next = 64'(cfg.normal_x) * 64'(s1_vx_reg);
        s2_vy_next = 64'(cfg.normal_y) * 64'(s1_vy_reg);
        s2_vz_next = 64'(cfg.normal_z) * 64'(s1_vz_reg);
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg  <= s1_op_reg;
        s2_rad_reg <= s1_rad_reg;
        s2_px_reg  <= s2_px_next;
        s2_py_reg  <= s2_py_next;
        s2_pz_reg  <= s2_pz_next;
        s2_vx_reg  <= s2_vx_next;
        s2_vy_reg  <= s2_vy_next;
        s2_vz_reg  <= s2_vz_next;
    end

    always_comb
    begin
        abs_x = s2_vx_reg[63] ? 64'(-s2_vx_reg) : 64'(s2_vx_reg);
        abs_y = s2_vy_reg[63] ? 64'(-s2_vy_reg) : 64'(s2_vy_reg);
        abs_z = s2_vz_reg[63] ? 64'(-s2_vz_reg) : 64'(s2_vz_reg);
        s3_dist_next = (s2_px_reg >>> FRAC_BITS) + (s2_py_reg >>> FRAC_BITS)
                     + (s2_pz_reg >>> FRAC_BITS) - 64'(cfg.plane_offset);
        s3_den_next  = (s2_vx_reg >>> FRAC_BITS) + (s2_vy_reg >>> FRAC_BITS)
                     + (s2_vz_reg >>> FRAC_BITS);
        s3_mb_next   = (abs_x >> (FRAC_BITS + 1)) + (abs_y >> (FRAC_BITS + 1))
                     + (abs_z >> (FRAC_BITS + 1));
    end

    always_ff @(posedge clk)
    begin
        s3_op_reg   <= s2_op_reg;
        s3_rad_reg  <= s2_rad_reg;
        s3_dist_reg <= s3_dist_next;
        s3_den_reg  <= s3_den_next;
        s3_mb_reg   <= s3_mb_next;
    end

    always_comb
    begin
        case (s3_op_reg)
            OP_SPHERE: bound = 64'({33'd0, s3_rad_reg});
            OP_BOX:    bound = s3_mb_reg;
            default:   bound = 64'({48'd0, cfg.epsilon});
        endcase
        mid = (s3_op_reg == OP_SPHERE || s3_op_reg == OP_BOX) ? SIDE_STRADDLE : SIDE_ON;
        anom = s3_dist_reg[63] ? 64'(-s3_dist_reg) : 64'(s3_dist_reg);
        aden = s3_den_reg[63] ? 64'(-s3_den_reg) : 64'(s3_den_reg);

        s4_next.valid = 1'b1;
        s4_next.num   = anom << FRAC_BITS;
        s4_next.den   = aden;
        if (s3_dist_reg > bound)
            s4_next.meta.side = SIDE_POS;
        else if (s3_dist_reg < -bound)
            s4_next.meta.side = SIDE_NEG;
        else
            s4_next.meta.side = mid;
        s4_next.meta.is_ray    = (s3_op_reg == OP_RAY);
        s4_next.meta.parallel  = (aden == 64'd0) || (aden < 64'({48'd0, cfg.epsilon}));
        s4_next.meta.same_sign = (s3_dist_reg[63] == s3_den_reg[63]);
        if (s3_dist_reg > 64'sd2147483647)
            s4_next.meta.dist_sat = 32'h7FFF_FFFF;
        else if (s3_dist_reg < -64'sd2147483648)
            s4_next.meta.dist_sat = 32'h8000_0000;
        else
            s4_next.meta.dist_sat = s3_dist_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        s4_reg <= s4_next;
    end

    always_comb
    begin
        req       = s4_reg;
        req.valid = s4_vld_reg;
    end

endmodule
`default_nettype wire

FILE: sv/pst_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`default_nettype none
module pst_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  pst_pkg::pst_div_req_t  req,
    output pst_pkg::pst_div_rsp_t  rsp
);
    import pst_pkg::*;

    logic        vld_reg  [DIV_STEPS+1];
    logic [63:0] rem_reg  [DIV_STEPS+1];
    logic [31:0] low_reg  [DIV_STEPS+1];
    logic [31:0] quo_reg  [DIV_STEPS+1];
    logic [63:0] den_reg  [DIV_STEPS+1];
    logic        ovf_reg  [DIV_STEPS+1];
    pst_meta_t   meta_reg [DIV_STEPS+1];

    logic        ovf_next;

    assign ovf_next = {32'd0, req.num[63:32]} >= req.den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= {32'd0, req.num[63:32]};
        low_reg[0]  <= req.num[31:0];
        quo_reg[0]  <= '0;
        den_reg[0]  <= req.den;
        ovf_reg[0]  <= ovf_next;
        meta_reg[0] <= req.meta;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [64:0] rem_x;
        logic        ge;
        logic [64:0] diff;
        logic [63:0] rem_next;

        always_comb
        begin
            rem_x    = {rem_reg[k], low_reg[k][31]};
            ge       = rem_x >= {1'b0, den_reg[k]};
            diff     = rem_x - {1'b0, den_reg[k]};
            rem_next = ge ? diff[63:0] : rem_x[63:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            low_reg[k+1]  <= {low_reg[k][30:0], 1'b0};
            quo_reg[k+1]  <= {quo_reg[k][30:0], ge};
            den_reg[k+1]  <= den_reg[k];
            ovf_reg[k+1]  <= ovf_reg[k];
            meta_reg[k+1] <= meta_reg[k];
        end
    end

    always_comb
    begin
        rsp.valid = vld_reg[DIV_STEPS];
        rsp.ovf   = ovf_reg[DIV_STEPS];
        rsp.quo   = quo_reg[DIV_STEPS];
        rsp.meta  = meta_reg[DIV_STEPS];
    end

endmodule
`default_nettype wire

FILE: sv/plane_side_and_ray_test_unit.sv
// Top level: plane side classification and ray intersection pipeline.
// Each accepted request reaches done through the front, divider and output registers.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the divider, one quotient bit per stage over 32 stages.
// Reset clears all valid bits and loads the plane registers with zero, epsilon one.
`default_nettype none
module plane_side_and_ray_test_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    input  wire logic [30:0]        radius,
    output logic                    done,
    output logic [1:0]              side,
    output logic                    hit,
    output logic signed [31:0]      hit_t,
    output logic signed [31:0]      signed_distance
);
    import pst_pkg::*;

    localparam int LATENCY = DIV_STEPS + 6;

    pst_cfg_t     cfg;
    pst_div_req_t req;
    pst_div_rsp_t rsp;

    logic        done_reg;
    logic [1:0]  side_reg;
    logic        hit_reg, hit_next;
    logic [31:0] t_reg, t_next;
    logic [31:0] dist_reg;
    logic [31:0] mag;
    logic        neg;

    assign busy = 1'b0;

    pst_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pst_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (start && !busy),
        .opcode   (opcode),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .vec_x    (vec_x),
        .vec_y    (vec_y),
        .vec_z    (vec_z),
        .radius   (radius),
        .req      (req)
    );

    pst_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        mag = (rsp.ovf || rsp.quo > 32'h8000_0000) ? 32'h8000_0000 : rsp.quo;
        neg = (rsp.ovf || rsp.quo != 32'd0) && rsp.meta.same_sign;
        if (!rsp.meta.is_ray || rsp.meta.parallel)
        begin
            hit_next = 1'b0;
            t_next   = 32'd0;
        end
        else
        begin
            hit_next = !neg;
            if (neg)
                t_next = ~mag + 32'd1;
            else
                t_next = mag[31] ? 32'h7FFF_FFFF : mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= rsp.valid;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= rsp.meta.side;
        hit_reg  <= hit_next;
        t_reg    <= t_next;
        dist_reg <= rsp.meta.dist_sat;
    end

    assign done            = done_reg;
    assign side            = side_reg;
    assign hit             = hit_reg;
    assign hit_t           = t_reg;
    assign signed_distance = dist_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("request did not complete at the pipeline latency");

    a_hit_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> !hit_t[31])
        else $error("hit reported with negative t");

    a_hit_side: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> side != SIDE_STRADDLE)
        else $error("ray hit carries a straddle class");

endmodule
`default_nettype wire

FILE: tb/plane_side_and_ray_test_unit_tb.sv
// Testbench for the plane side and ray test unit: random and directed requests checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module plane_side_and_ray_test_unit_tb;
    import pst_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]         side;
        logic               hit;
        logic signed [31:0] hit_t;
        logic signed [31:0] sdist;
    } plane_result_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] px, py, pz, vx, vy, vz;
        logic [30:0]        rad;
    } plane_query_t;

    class plane_scoreboard;
        logic signed [31:0] nx, ny, nz, ofs;
        logic [15:0]        eps;
        plane_result_t      pending[$];
        int                 errors;

        function new();
            nx = 0; ny = 0; nz = 0; ofs = 0; eps = 16'd1; errors = 0;
        endfunction

        function logic signed [63:0] floor_shift(logic signed [63:0] x);
            return x >>> FRAC;
        endfunction

        function logic signed [63:0] dot(logic signed [31:0] ax, logic signed [31:0] ay,
                                         logic signed [31:0] az);
            logic signed [63:0] s;
            s = floor_shift(64'(nx) * 64'(ax)) + floor_shift(64'(ny) * 64'(ay))
                + floor_shift(64'(nz) * 64'(az));
            return s;
        endfunction

        function logic [63:0] abs_prod(logic signed [31:0] a, logic signed [31:0] b);
            logic signed [63:0] p;
            p = 64'(a) * 64'(b);
            return p < 0 ? 64'(-p) : 64'(p);
        endfunction

        function logic signed [31:0] sat(logic signed [63:0] v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function logic [1:0] classify(logic signed [63:0] d, logic signed [63:0] b,
                                      logic [1:0] mid);
            if (d > b) return SIDE_POS;
            if (d < -b) return SIDE_NEG;
            return mid;
        endfunction

        function void note_request(plane_query_t q);
            plane_result_t r;
            logic signed [63:0] d, den, bnd;
            logic [63:0] aden, anum, quo;
            logic neg;
            d = dot(q.px, q.py, q.pz) - 64'(ofs);
            r.hit = 1'b0;
            r.hit_t = '0;
            case (q.op)
                OP_SPHERE: r.side = classify(d, 64'(q.rad), SIDE_STRADDLE);
                OP_BOX:
                begin
                    bnd = (abs_prod(nx, q.vx) >> (FRAC + 1)) + (abs_prod(ny, q.vy) >> (FRAC + 1))
                        + (abs_prod(nz, q.vz) >> (FRAC + 1));
                    r.side = classify(d, bnd, SIDE_STRADDLE);
                end
                default:
                begin
                    r.side = classify(d, 64'(eps), SIDE_ON);
                    if (q.op == OP_RAY)
                    begin
                        den = dot(q.vx, q.vy, q.vz);
                        aden = den < 0 ? 64'(-den) : 64'(den);
                        if (aden != 0 && aden >= 64'(eps))
                        begin
                            anum = d < 0 ? 64'(-d) : 64'(d);
                            quo = (anum << FRAC) / aden;
                            neg = (quo != 0) && ((d < 0) == (den < 0));
                            if (quo > 64'h80000000) quo = 64'h80000000;
                            r.hit_t = sat(neg ? -$signed(quo) : $signed(quo));
                            r.hit = !neg;
                        end
                    end
                end
            endcase
            r.sdist = sat(d);
            pending.push_back(r);
        endfunction

        function void check_result(plane_result_t got);
            plane_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.side !== e.side)
            begin
                $error("side: expected %0d actual %0d", e.side, got.side);
                errors++;
            end
            if (got.hit !== e.hit)
            begin
                $error("hit: expected %0d actual %0d", e.hit, got.hit);
                errors++;
            end
            if (got.hit_t !== e.hit_t)
            begin
                $error("hit_t: expected %0d actual %0d", e.hit_t, got.hit_t);
                errors++;
            end
            if (got.sdist !== e.sdist)
            begin
                $error("signed_distance: expected %0d actual %0d", e.sdist, got.sdist);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic pready, start = 0, busy, done, hit;
    logic [1:0] opcode = '0, side;
    logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0, vec_x = 0, vec_y = 0, vec_z = 0;
    logic [30:0] radius = '0;
    logic signed [31:0] hit_t, signed_distance;
    int idle_cycles = 0;

    plane_scoreboard sb = new();

    plane_side_and_ray_test_unit #(.FRAC_BITS(FRAC)) dut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (done)
            sb.check_result({side, hit, hit_t, signed_distance});
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("plane_side_and_ray_test_unit_tb: done, errors");
            $finish;
        end
    end

    function logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            4, 5: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            default: return $urandom;
        endcase
    endfunction

    task write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        case (idx)
            REG_NORMAL_X: sb.nx = val;
            REG_NORMAL_Y: sb.ny = val;
            REG_NORMAL_Z: sb.nz = val;
            REG_OFFSET:   sb.ofs = val;
            default:      sb.eps = val[15:0];
        endcase
    endtask

    task set_plane(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] o,
                   logic [15:0] e);
        write_reg(REG_NORMAL_X, x);
        write_reg(REG_NORMAL_Y, y);
        write_reg(REG_NORMAL_Z, z);
        write_reg(REG_OFFSET, o);
        write_reg(REG_EPSILON, {16'h0, e});
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task drain();
        start <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task send_request(plane_query_t q, bit gaps);
        int n;
        n = gaps ? $urandom_range(0, 13) : 0;
        if (n > 0)
        begin
            start <= 0;
            repeat (n) @(posedge clk);
        end
        start <= 1;
        opcode <= q.op;
        pos_x <= q.px; pos_y <= q.py; pos_z <= q.pz;
        vec_x <= q.vx; vec_y <= q.vy; vec_z <= q.vz;
        radius <= q.rad;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_request(q);
    endtask

    function plane_query_t rand_query();
        plane_query_t q;
        q.op = 2'($urandom_range(0, 3));
        q.px = rand_word(); q.py = rand_word(); q.pz = rand_word();
        q.vx = rand_word(); q.vy = rand_word(); q.vz = rand_word();
        q.rad = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 32'h3ffff));
        return q;
    endfunction

    initial
    begin
        plane_query_t q;
        bit gaps;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        set_plane(32'h00010000, 32'h0, 32'h0, 32'h00020000, 16'd4);
        for (int op = 0; op < 4; op++)
        begin
            q = '{op: 2'(op), px: 32'h00020000, py: 32'h0, pz: 32'h0, vx: 32'h00010000,
                  vy: 32'h0, vz: 32'h0, rad: 31'h0};
            send_request(q, 0);
            q.px = 32'h7fffffff; q.py = 32'h80000000; q.vx = 32'hffff0000;
            q.rad = 31'h7fffffff;
            send_request(q, 0);
            q.px = 32'h80000000; q.vx = 32'h0; q.vy = 32'h7fffffff; q.rad = 31'h00010000;
            send_request(q, 0);
            q.px = 32'h00020003; q.vx = 32'h00000002; q.vz = 32'h80000000;
            send_request(q, 0);
            q.px = 32'h0001ffff; q.vx = 32'hfffe0000; q.vy = 32'h0;
            send_request(q, 0);
        end
        drain();
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 16'hffff);
                1: set_plane(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 16'h0);
                2: set_plane(32'h0, 32'h0, 32'h0, 32'h0, 16'h0);
                default: set_plane(rand_word(), rand_word(), rand_word(), rand_word(),
                                   $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8)));
            endcase
            for (int i = 0; i < 120; i++)
            begin
                gaps = (i / 30) % 2 == 1;
                send_request(rand_query(), gaps);
                if (i == 60) drain();
            end
            drain();
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("plane_side_and_ray_test_unit_tb: done, clean");
        else
            $display("plane_side_and_ray_test_unit_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
